// ===== hw/rtl/etsu_pkg.sv =====
// Shared types, codes and character constants for the expression token splitter.
// No dependencies; the top-level module in hw/rtl refers to this package by scoped name.
`default_nettype none

package etsu_pkg;

  // Token slot count that the default build is sized for
  localparam int unsigned MaxTokenSlots = 64;

  // Configuration port geometry: one 32-bit register at byte address 0
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [0:0]  REG_MAX_TOKENS = 1'b0;
  localparam logic [6:0]  MaxTokensReset = 7'd64;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_QUIT     = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_TWO_DOTS = 3'd3,
    ST_DOT_EDGE = 3'd4,
    ST_TOO_MANY = 3'd5,
    ST_IGNORED  = 3'd6
  } status_t;

  typedef enum logic {
    KIND_NUMBER = 1'b0,
    KIND_SYMBOL = 1'b1
  } kind_t;

  // Character codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_Q_LO  = 8'h71;
  localparam logic [7:0] CH_Q_UP  = 8'h51;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // One result word
  typedef struct packed {
    logic       token_start;
    kind_t      token_kind;
    logic [5:0] token_index;
    logic       number_closed;
    status_t    status;
    logic [6:0] token_total;
    logic       line_done;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Operators and brackets: + - * / % ( ) ^ [ ] { } = < > @ ~ $ ! # & ?
  function automatic logic is_symbol(input logic [7:0] c);
    logic hit;
    unique case (c)
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h28, 8'h29, 8'h5E,
      8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3D, 8'h3C, 8'h3E, 8'h40,
      8'h7E, 8'h24, 8'h21, 8'h23, 8'h26, 8'h3F: hit = 1'b1;
      default:                                  hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/etsu_in_if.sv =====
// Character channel: valid/ready handshake with one character word.
// No dependencies.
`default_nettype none

interface etsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_in_line;

  modport source (output valid, output char_code, output last_in_line, input ready);
  modport sink   (input valid, input char_code, input last_in_line, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/etsu_out_if.sv =====
// Result channel: valid/ready handshake with one token result word.
// No dependencies.
`default_nettype none

interface etsu_out_if;
  logic       valid;
  logic       ready;
  logic       token_start;
  logic       token_kind;
  logic [5:0] token_index;
  logic       number_closed;
  logic [2:0] status;
  logic [6:0] token_total;
  logic       line_done;

  modport source (output valid, output token_start, output token_kind, output token_index,
                  output number_closed, output status, output token_total,
                  output line_done, input ready);
  modport sink   (input valid, input token_start, input token_kind, input token_index,
                  input number_closed, input status, input token_total,
                  input line_done, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/expression_token_splitter_unit.sv =====
// Expression token splitter top level: character register, lexer logic, result register.
// Depends on etsu_pkg, etsu_in_if and etsu_out_if.
//
//   channel   | direction | word                        | handshake
//   ----------+-----------+-----------------------------+------------------------------
//   chars     | in        | char_code, last_in_line     | valid/ready
//   tokens    | out       | start/kind/index/close/etc. | valid/ready
//   apb       | in        | max_tokens (byte addr 0)    | psel/penable/pwrite, pready=1
//
// One character word per cycle, sustained while tokens.ready is high. A word accepted
// on chars passes the character register, then the result register, before its result
// shows on tokens. The lexer state (open number, dot tally, token count, stop flag)
// advances when the character register hands its word to the result register.
// Synchronous active-high reset clears all control state and sets max_tokens to 64.
// A stall on tokens fills the result register, then the character register, then
// drops chars.ready; no word is lost or repeated.
`default_nettype none

module expression_token_splitter_unit #(
  parameter int unsigned MAX_TOKEN_SLOTS = etsu_pkg::MaxTokenSlots
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [etsu_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [etsu_pkg::CfgDataW-1:0] pwdata,
  output      logic [etsu_pkg::CfgDataW-1:0] prdata,
  output      logic                          pready,
  // streams
  etsu_in_if.sink                            chars,
  etsu_out_if.source                         tokens
);

  // Token counter holds 0..MAX_TOKEN_SLOTS; compare width covers the 7-bit register too
  localparam int unsigned TW = $clog2(MAX_TOKEN_SLOTS + 1);
  localparam int unsigned LW = (TW > 7) ? TW : 7;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [6:0] max_tokens;
  logic       sel_max_tokens;

  assign pready         = 1'b1;
  assign sel_max_tokens = (paddr[2] == etsu_pkg::REG_MAX_TOKENS);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tokens <= etsu_pkg::MaxTokensReset;
    end else if (psel && penable && pwrite && pready && sel_max_tokens) begin
      max_tokens <= pwdata[6:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_max_tokens) begin
      prdata = {{(etsu_pkg::CfgDataW-7){1'b0}}, max_tokens};
    end
  end

  // Effective limit: zero acts as one, anything above the slot count clamps to it
  logic [LW-1:0] limit;

  always_comb begin
    if (max_tokens == 7'd0) begin
      limit = LW'(1);
    end else if (LW'(max_tokens) > LW'(MAX_TOKEN_SLOTS)) begin
      limit = LW'(MAX_TOKEN_SLOTS);
    end else begin
      limit = LW'(max_tokens);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic         s1_valid;
  logic [7:0]   s1_char;
  logic         s1_last;
  logic         res_valid;
  etsu_pkg::res_t res;
  etsu_pkg::res_t res_next;
  logic         advance;

  // Hand the character word on whenever the result register is free or draining
  assign advance     = s1_valid && (!res_valid || tokens.ready);
  assign chars.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (chars.ready) begin
        s1_valid <= chars.valid;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (tokens.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      s1_char <= chars.char_code;
      s1_last <= chars.last_in_line;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign tokens.valid         = res_valid;
  assign tokens.token_start   = res.token_start;
  assign tokens.token_kind    = logic'(res.token_kind);
  assign tokens.token_index   = res.token_index;
  assign tokens.number_closed = res.number_closed;
  assign tokens.status        = 3'(res.status);
  assign tokens.token_total   = res.token_total;
  assign tokens.line_done     = res.line_done;

  // ---------------------------------------------------------------------------
  // Lexer state
  // ---------------------------------------------------------------------------
  logic          in_number,   in_number_next;
  logic [1:0]    dot_tally,   dot_tally_next;
  logic          began_dot,   began_dot_next;
  logic          prev_dot,    prev_dot_next;
  logic [TW-1:0] tokens_seen, tokens_seen_next;
  logic          stopped,     stopped_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_number   <= 1'b0;
      dot_tally   <= 2'd0;
      began_dot   <= 1'b0;
      prev_dot    <= 1'b0;
      tokens_seen <= '0;
      stopped     <= 1'b0;
    end else if (advance) begin
      in_number   <= in_number_next;
      dot_tally   <= dot_tally_next;
      began_dot   <= began_dot_next;
      prev_dot    <= prev_dot_next;
      tokens_seen <= tokens_seen_next;
      stopped     <= stopped_next;
    end
  end

  // Checks on a closing number: too many dots, dot at either edge, then the count
  function automatic etsu_pkg::status_t close_status(input logic [1:0]    tally,
                                                     input logic          began,
                                                     input logic          prev,
                                                     input logic [TW-1:0] count,
                                                     input logic [LW-1:0] lim);
    etsu_pkg::status_t st;
    if (tally >= 2'd2) begin
      st = etsu_pkg::ST_TWO_DOTS;
    end else if (began || prev) begin
      st = etsu_pkg::ST_DOT_EDGE;
    end else if (LW'(count) >= lim) begin
      st = etsu_pkg::ST_TOO_MANY;
    end else begin
      st = etsu_pkg::ST_OK;
    end
    return st;
  endfunction

  logic              is_dot;
  logic              is_num;
  logic              start;
  etsu_pkg::kind_t   kind;
  logic [TW-1:0]     idx;
  logic              closed;
  etsu_pkg::status_t st;
  logic              done;
  logic [LW-1:0]     idx_ext;
  logic [LW-1:0]     total_ext;

  always_comb begin
    is_dot = (s1_char == etsu_pkg::CH_DOT);
    is_num = etsu_pkg::is_digit(s1_char) || is_dot;

    in_number_next   = in_number;
    dot_tally_next   = dot_tally;
    began_dot_next   = began_dot;
    prev_dot_next    = prev_dot;
    tokens_seen_next = tokens_seen;
    stopped_next     = stopped;

    start  = 1'b0;
    kind   = etsu_pkg::KIND_NUMBER;
    idx    = '0;
    closed = 1'b0;
    st     = etsu_pkg::ST_OK;
    done   = 1'b0;

    if (stopped) begin
      // Drop everything up to the end of the line
      st = etsu_pkg::ST_IGNORED;
    end else begin
      // Close an open number ahead of any non-number character
      if (in_number && !is_num) begin
        closed         = 1'b1;
        st             = close_status(dot_tally, began_dot, prev_dot, tokens_seen, limit);
        in_number_next = 1'b0;
        dot_tally_next = 2'd0;
        began_dot_next = 1'b0;
        prev_dot_next  = 1'b0;
      end

      if (st == etsu_pkg::ST_OK) begin
        priority if (etsu_pkg::is_space(s1_char)) begin
          // whitespace: skip
        end else if (s1_char == etsu_pkg::CH_Q_LO || s1_char == etsu_pkg::CH_Q_UP) begin
          st = etsu_pkg::ST_QUIT;
        end else if (is_num) begin
          if (!in_number_next) begin
            start            = 1'b1;
            kind             = etsu_pkg::KIND_NUMBER;
            idx              = tokens_seen_next;
            tokens_seen_next = tokens_seen_next + 1'b1;
            in_number_next   = 1'b1;
            dot_tally_next   = 2'd0;
            began_dot_next   = is_dot;
          end
          // Saturate the dot tally at two
          if (is_dot && dot_tally_next < 2'd2) begin
            dot_tally_next = dot_tally_next + 2'd1;
          end
          prev_dot_next = is_dot;
        end else if (etsu_pkg::is_symbol(s1_char)) begin
          start            = 1'b1;
          kind             = etsu_pkg::KIND_SYMBOL;
          idx              = tokens_seen_next;
          tokens_seen_next = tokens_seen_next + 1'b1;
          if (LW'(tokens_seen_next) >= limit) begin
            st = etsu_pkg::ST_TOO_MANY;
          end
        end else begin
          st = etsu_pkg::ST_UNKNOWN;
        end
      end

      // End of line closes a number that is still open, after taking this character
      if (st == etsu_pkg::ST_OK && s1_last && in_number_next) begin
        closed = 1'b1;
        st     = close_status(dot_tally_next, began_dot_next, prev_dot_next,
                              tokens_seen_next, limit);
        in_number_next = 1'b0;
        dot_tally_next = 2'd0;
        began_dot_next = 1'b0;
        prev_dot_next  = 1'b0;
      end

      // Any fault or quit stops the line
      if (st != etsu_pkg::ST_OK) begin
        stopped_next   = 1'b1;
        in_number_next = 1'b0;
        dot_tally_next = 2'd0;
        began_dot_next = 1'b0;
        prev_dot_next  = 1'b0;
        done           = 1'b1;
      end
    end

    if (s1_last) begin
      done = 1'b1;
    end

    idx_ext   = LW'(idx);
    total_ext = LW'(tokens_seen_next);

    res_next.token_start   = start;
    res_next.token_kind    = kind;
    res_next.token_index   = idx_ext[5:0];
    res_next.number_closed = closed;
    res_next.status        = st;
    res_next.token_total   = total_ext[6:0];
    res_next.line_done     = done;

    // Line end: clear all line state for the next line
    if (s1_last) begin
      in_number_next   = 1'b0;
      dot_tally_next   = 2'd0;
      began_dot_next   = 1'b0;
      prev_dot_next    = 1'b0;
      tokens_seen_next = '0;
      stopped_next     = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // A non-ok status in mid-line must leave the line stopped
  a_stop_sticks: assert property (@(posedge clk) disable iff (rst)
    advance && res_next.status != etsu_pkg::ST_OK && !s1_last |=> stopped)
    else $error("line not stopped after a fault or quit");

  // The token count never runs past the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    LW'(tokens_seen) <= LW'(MAX_TOKEN_SLOTS))
    else $error("token count beyond slot count");

  // The last character of a line leaves clean line state behind
  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    advance && s1_last |=> tokens_seen == '0 && !stopped && !in_number && dot_tally == 2'd0)
    else $error("line state not cleared at line end");

  // A result word held under stall keeps its contents
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !tokens.ready |=> res_valid && $stable(res))
    else $error("result word changed under stall");

endmodule

`default_nettype wire
